// ----- rtl/nblbq_pkg.sv -----
package nblbq_pkg;

   // Fixed field and datapath widths.
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 24;
   localparam int COEF_FRAC  = 22;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 14;
   localparam int STATE_W    = 48;
   localparam int HALF_W     = 24;
   localparam int PROD_W     = HALF_W + 1 + COEF_W;
   localparam int ACC_W      = 54;
   localparam int GPROD_W    = HALF_W + 1 + GAIN_W + 1;
   localparam int FULL_W     = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_FEED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_FB1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_FB2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_FEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_FB1  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_FB2  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BYPASS      = 3'd7;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

   localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Coefficients of one biquad section.
   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } bq_coef_type;

   // A value handed from one section to the next.
   typedef struct packed {
      logic                      valid;
      logic signed [STATE_W-1:0] data;
   } bq_link_type;

   // Finished output word of the gain unit.
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
   } bq_res_type;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_XLO   = 11'b000_0000_0010,
      S_XHI   = 11'b000_0000_0100,
      S_PCOMB = 11'b000_0000_1000,
      S_YSUM  = 11'b000_0001_0000,
      S_A1LO  = 11'b000_0010_0000,
      S_A1HI  = 11'b000_0100_0000,
      S_M1    = 11'b000_1000_0000,
      S_A2HI  = 11'b001_0000_0000,
      S_M2    = 11'b010_0000_0000,
      S_W1    = 11'b100_0000_0000
   } bq_cell_state_type;

   typedef enum logic [5:0] {
      G_IDLE = 6'b00_0001,
      G_LO   = 6'b00_0010,
      G_HI   = 6'b00_0100,
      G_SUM  = 6'b00_1000,
      G_RND  = 6'b01_0000,
      G_HOLD = 6'b10_0000
   } bq_gain_state_type;

   // Sign-extend a state word to accumulator width.
   function automatic logic signed [ACC_W-1:0] widen(input logic signed [STATE_W-1:0] v);
      return {{(ACC_W-STATE_W){v[STATE_W-1]}}, v};
   endfunction

   // Clamp an accumulator value to the signed state range.
   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      if (v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[ACC_W-1]}}) begin
         return v[STATE_W-1:0];
      end else if (v[ACC_W-1]) begin
         return STATE_MIN;
      end else begin
         return STATE_MAX;
      end
   endfunction

   // Join the upper and lower partial products into floor(a * c / 2^22).
   function automatic logic signed [ACC_W-1:0] mulq_combine(
      input logic signed [PROD_W-1:0] hi_prod,
      input logic signed [PROD_W-1:0] lo_prod);
      logic signed [ACC_W-1:0] hi_term;
      logic signed [ACC_W-1:0] lo_term;
      hi_term = {{(ACC_W-PROD_W){hi_prod[PROD_W-1]}}, hi_prod} <<< (HALF_W - COEF_FRAC);
      lo_term = {{(ACC_W-PROD_W+COEF_FRAC){lo_prod[PROD_W-1]}},
                 lo_prod[PROD_W-1:COEF_FRAC]};
      return hi_term + lo_term;
   endfunction

endpackage

// ----- rtl/nblbq_cell.sv -----
module nblbq_cell import nblbq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bq_coef_type coef,
   input  bq_link_type link_in,
   output bq_link_type link_out,
   output logic        busy
);

   bq_cell_state_type state_ff, state_in;

   logic signed [STATE_W-1:0] x_ff, x_in;
   logic signed [STATE_W-1:0] y_ff, y_in;
   logic signed [STATE_W-1:0] w0_ff, w0_in;
   logic signed [STATE_W-1:0] w1_ff, w1_in;
   logic signed [ACC_W-1:0]   p_ff, p_in;
   logic signed [ACC_W-1:0]   m_ff, m_in;
   logic signed [ACC_W-1:0]   mq;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  lo_ff;
   logic        [STATE_W-1:0] mul_src;
   logic                      half_lo;
   logic signed [HALF_W:0]    mul_a;
   logic signed [COEF_W-1:0]  mul_c;

   // One 25x24 multiplier, fed one half of a 48-bit word per cycle.
   always_comb begin
      mul_src = (state_ff inside {S_XLO, S_XHI}) ? x_ff : y_ff;
      half_lo = state_ff inside {S_XLO, S_A1LO, S_M1};
      if (half_lo) begin
         mul_a = $signed({1'b0, mul_src[HALF_W-1:0]});
      end else begin
         mul_a = $signed({mul_src[STATE_W-1], mul_src[STATE_W-1:HALF_W]});
      end
      if (state_ff inside {S_XLO, S_XHI}) begin
         mul_c = coef.b0;
      end else if (state_ff inside {S_A1LO, S_A1HI}) begin
         mul_c = coef.a1;
      end else begin
         mul_c = coef.a2;
      end
      prod_in = mul_a * mul_c;
      mq      = mulq_combine(prod_ff, lo_ff);
   end

   // Section sequence: b0 product, output, a1 product, w0 update, a2 product, w1 update.
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      w0_in    = w0_ff;
      w1_in    = w1_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      case (state_ff)
         S_IDLE: begin
            if (link_in.valid) begin
               x_in     = link_in.data;
               state_in = S_XLO;
            end
         end
         S_XLO:   state_in = S_XHI;
         S_XHI:   state_in = S_PCOMB;
         S_PCOMB: begin
            p_in     = mq;
            state_in = S_YSUM;
         end
         S_YSUM: begin
            y_in     = sat_state(p_ff + widen(w0_ff));
            state_in = S_A1LO;
         end
         S_A1LO:  state_in = S_A1HI;
         S_A1HI:  state_in = S_M1;
         S_M1: begin
            m_in     = mq;
            state_in = S_A2HI;
         end
         S_A2HI: begin
            w0_in    = sat_state((p_ff <<< 1) - m_ff + widen(w1_ff));
            state_in = S_M2;
         end
         S_M2: begin
            m_in     = mq;
            state_in = S_W1;
         end
         S_W1: begin
            w1_in    = sat_state(p_ff - m_ff);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state and delay words.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         w0_ff    <= '0;
         w1_ff    <= '0;
      end else begin
         state_ff <= state_in;
         w0_ff    <= w0_in;
         w1_ff    <= w1_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      p_ff    <= p_in;
      m_ff    <= m_in;
      prod_ff <= prod_in;
      lo_ff   <= prod_ff;
   end

   assign link_out.valid = (state_ff == S_W1);
   assign link_out.data  = y_ff;
   assign busy           = (state_ff != S_IDLE);

endmodule

// ----- rtl/nblbq_gain.sv -----
module nblbq_gain import nblbq_pkg::*; #(
   parameter int STATE_FRAC_BITS = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [GAIN_W-1:0] gain,
   input  bq_link_type       link_in,
   input  logic              take,
   output bq_res_type        result,
   output logic              busy
);

   localparam int SHIFT = STATE_FRAC_BITS + GAIN_FRAC;

   bq_gain_state_type state_ff, state_in;

   logic signed [STATE_W-1:0]  y_ff, y_in;
   logic signed [GPROD_W-1:0]  prod_ff, prod_in;
   logic signed [GPROD_W-1:0]  lo_ff;
   logic signed [FULL_W-1:0]   full_ff, full_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic signed [HALF_W:0]     mul_a;
   logic signed [GAIN_W:0]     mul_g;
   logic signed [FULL_W-1:0]   quot;
   logic signed [FULL_W-1:0]   quot_tz;
   logic                       round_up;

   // Gain multiply in two halves of the filter output.
   always_comb begin
      if (state_ff == G_LO) begin
         mul_a = $signed({1'b0, y_ff[HALF_W-1:0]});
      end else begin
         mul_a = $signed({y_ff[STATE_W-1], y_ff[STATE_W-1:HALF_W]});
      end
      mul_g   = $signed({1'b0, gain});
      prod_in = mul_a * mul_g;
   end

   // Scale back with truncation toward zero, then clamp to 16 bits.
   always_comb begin
      quot     = full_ff >>> SHIFT;
      round_up = full_ff[FULL_W-1] && (full_ff[SHIFT-1:0] != '0);
      quot_tz  = quot + $signed({{(FULL_W-1){1'b0}}, round_up});
   end

   always_comb begin
      state_in = state_ff;
      y_in     = y_ff;
      full_in  = full_ff;
      res_in   = res_ff;
      case (state_ff)
         G_IDLE: begin
            if (link_in.valid) begin
               y_in     = link_in.data;
               state_in = G_LO;
            end
         end
         G_LO:  state_in = G_HI;
         G_HI:  state_in = G_SUM;
         G_SUM: begin
            full_in  = ({{(FULL_W-GPROD_W){prod_ff[GPROD_W-1]}}, prod_ff} <<< HALF_W)
                     + {{(FULL_W-GPROD_W){lo_ff[GPROD_W-1]}}, lo_ff};
            state_in = G_RND;
         end
         G_RND: begin
            if (quot_tz[FULL_W-1:SAMPLE_W-1] == {(FULL_W-SAMPLE_W+1){quot_tz[FULL_W-1]}}) begin
               res_in = quot_tz[SAMPLE_W-1:0];
            end else if (quot_tz[FULL_W-1]) begin
               res_in = SAMPLE_MIN;
            end else begin
               res_in = SAMPLE_MAX;
            end
            state_in = G_HOLD;
         end
         G_HOLD: begin
            if (take) begin
               state_in = G_IDLE;
            end
         end
         default: state_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      prod_ff <= prod_in;
      lo_ff   <= prod_ff;
      full_ff <= full_in;
      res_ff  <= res_in;
   end

   assign result.valid  = (state_ff == G_HOLD);
   assign result.sample = res_ff;
   assign busy          = (state_ff != G_IDLE);

endmodule

// ----- rtl/noise_band_limit_biquad_cascade_core.sv -----
// Noise band-limiting filter: each accepted word is a signed 16-bit sample that
// runs through STAGES transposed direct-form-II lowpass sections in a chain,
// is scaled by the Q2.14 output gain and clamped to 16 bits; every word gives
// exactly one result word, with its last flag copied. One word is in flight at
// a time. Each section has its own 25x24 multiplier that makes six passes per
// sample (b0, a1 and a2 times a 48-bit value, in two halves each); the word then
// goes through the gain unit, and the next word is accepted only once the result
// has moved into the output register. With bypass set a word is passed through
// unchanged and the delay words hold. Coefficients are Q2.22; sections after the
// second reuse the second section's registers. Write the control registers only
// while no word is in flight.
module noise_band_limit_biquad_cascade_core import nblbq_pkg::*; #(
   parameter int STAGES          = 2,
   parameter int STATE_FRAC_BITS = 22
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   input  logic                       req_in_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_out_sample,
   output logic                       rsp_out_last,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   bq_coef_type         first_coef_ff, first_coef_in;
   bq_coef_type         second_coef_ff, second_coef_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic                bypass_ff, bypass_in;

   logic                busy_ff, busy_in;
   logic                byp_valid_ff, byp_valid_in;
   logic signed [SAMPLE_W-1:0] byp_sample_ff;
   logic                last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                rsp_last_ff;

   logic                accept;
   logic                move;
   logic                src_valid;
   logic signed [SAMPLE_W-1:0] src_sample;
   logic [STAGES-1:0]   cell_busy;
   logic                gain_busy;
   bq_link_type         links [STAGES+1];
   bq_res_type          gain_res;

   // Control registers.
   always_comb begin
      first_coef_in  = first_coef_ff;
      second_coef_in = second_coef_ff;
      gain_in        = gain_ff;
      bypass_in      = bypass_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FIRST_FEED:  first_coef_in.b0  = csr_wdata[COEF_W-1:0];
            REG_FIRST_FB1:   first_coef_in.a1  = csr_wdata[COEF_W-1:0];
            REG_FIRST_FB2:   first_coef_in.a2  = csr_wdata[COEF_W-1:0];
            REG_SECOND_FEED: second_coef_in.b0 = csr_wdata[COEF_W-1:0];
            REG_SECOND_FB1:  second_coef_in.a1 = csr_wdata[COEF_W-1:0];
            REG_SECOND_FB2:  second_coef_in.a2 = csr_wdata[COEF_W-1:0];
            REG_GAIN:        gain_in           = csr_wdata[GAIN_W-1:0];
            REG_BYPASS:      bypass_in         = csr_wdata[0];
            default:         bypass_in         = bypass_ff;
         endcase
      end
   end

   // Input side: one word at a time.
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;

   // First section takes the sample in the state format.
   assign links[0].valid = accept && !bypass_ff;
   assign links[0].data  = {{(STATE_W-SAMPLE_W){req_in_sample[SAMPLE_W-1]}}, req_in_sample}
                           <<< STATE_FRAC_BITS;

   // Chain of sections, each handing its output to the next.
   for (genvar s = 0; s < STAGES; s++) begin : g_cell
      nblbq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .coef     ((s == 0) ? first_coef_ff : second_coef_ff),
         .link_in  (links[s]),
         .link_out (links[s+1]),
         .busy     (cell_busy[s])
      );
   end

   nblbq_gain #(
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_gain (
      .clock   (clock),
      .reset   (reset),
      .gain    (gain_ff),
      .link_in (links[STAGES]),
      .take    (move && !byp_valid_ff),
      .result  (gain_res),
      .busy    (gain_busy)
   );

   // Result source and transfer into the output register.
   assign src_valid  = byp_valid_ff || gain_res.valid;
   assign src_sample = byp_valid_ff ? byp_sample_ff : gain_res.sample;
   assign move       = src_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      busy_in      = busy_ff;
      byp_valid_in = byp_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         busy_in      = 1'b1;
         byp_valid_in = bypass_ff;
      end else if (move) begin
         busy_in      = 1'b0;
         byp_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_coef_ff  <= '0;
         second_coef_ff <= '0;
         gain_ff        <= GAIN_RESET;
         bypass_ff      <= 1'b1;
         busy_ff        <= 1'b0;
         byp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         first_coef_ff  <= first_coef_in;
         second_coef_ff <= second_coef_in;
         gain_ff        <= gain_in;
         bypass_ff      <= bypass_in;
         busy_ff        <= busy_in;
         byp_valid_ff   <= byp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         byp_sample_ff <= req_in_sample;
         last_ff       <= req_in_last;
      end
      if (move) begin
         rsp_sample_ff <= src_sample;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_out_last   = rsp_last_ff;

`ifndef SYNTHESIS
   // Only one section or the gain unit works on the word in flight.
   a_one_active: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cell_busy, gain_busy}))
      else $error("more than one unit of the chain is active");

   // With no word in flight the whole chain is quiet.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (cell_busy == '0) && !gain_busy && !byp_valid_ff)
      else $error("chain active with no word in flight");

   // A result only reaches the output register for a word in flight.
   a_move_busy: assert property (@(posedge clock) disable iff (reset)
      move |-> busy_ff)
      else $error("result produced with no word in flight");

   // A new word is never taken in the cycle a result moves out.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      accept |-> !src_valid)
      else $error("result source valid at acceptance");
`endif

endmodule
